// ===== hdl/psi_pkg.sv =====
package psi_pkg;

  // Operation selector carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_SENSOR    = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_SAFE = 2'd0,
    MODE_WARN = 2'd1,
    MODE_CRIT = 2'd2,
    MODE_STOP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_NOT_READY = 3'd1,
    CAUSE_INVALID   = 3'd2,
    CAUSE_OVER      = 3'd3,
    CAUSE_RUNAWAY   = 3'd4,
    CAUSE_FAIL_RUN  = 3'd5,
    CAUSE_SENSOR    = 3'd6,
    CAUSE_SPARE     = 3'd7
  } cause_t;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_MAX_PRESSURE   = 3'd0,
    REG_WARN_THRESHOLD = 3'd1,
    REG_TISSUE_LIMIT   = 3'd2,
    REG_VALID_LOW      = 3'd3,
    REG_VALID_HIGH     = 3'd4,
    REG_MAX_FAIL_RUN   = 3'd5,
    REG_RUNAWAY_SPEED  = 3'd6,
    REG_NONE           = 3'd7
  } reg_idx_t;

  localparam int VENT_FULL_BIT = 0;
  localparam int VENT_SEAL_BIT = 1;

  localparam int REQUIRED_RUN_DEFAULT = 5;
  localparam int COUNT_WIDTH_DEFAULT  = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int REPORT_W   = 16;
  localparam int ADDR_W     = 5;

  localparam logic [9:0]         MAX_PRESSURE_RST   = 10'd1000;
  localparam logic [9:0]         WARN_THRESHOLD_RST = 10'd800;
  localparam logic [14:0]        TISSUE_LIMIT_RST   = 15'd1500;
  localparam logic signed [15:0] VALID_LOW_RST      = 16'sd0;
  localparam logic signed [15:0] VALID_HIGH_RST     = 16'sd3000;
  localparam logic [7:0]         MAX_FAIL_RUN_RST   = 8'd3;
  localparam logic [6:0]         RUNAWAY_SPEED_RST  = 7'd80;

endpackage

// ===== hdl/pressure_safety_interlock_unit.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// --------  ---  -----------------------------------------------------------------
// s_axis    in   tuser: operation[1:0]; tdata: avl_pressure[15:0],
//                tank_pressure[31:16], pump_speed[38:32], hw_ready[39]
// m_axis    out  tdata: safety_state, vent_action, pulses, check_failed,
//                fault_cause, failure_run, three event counts (72 bits)
// apb       in   seven 32-bit registers at byte addresses 0x00 to 0x18
//
// One beat a cycle, sustained while m_tready stays high. An accepted beat is
// captured in the input register, the interlock logic evaluates it against the
// live state and the result register captures the outcome.
// A stalled result register holds the input register, which then drops tready;
// a beat is still taken in the same cycle the result is drained.
// rst (synchronous) returns the registers to their defaults and clears all state.
module pressure_safety_interlock_unit #(
  parameter int REQUIRED_RUN = psi_pkg::REQUIRED_RUN_DEFAULT,
  parameter int COUNT_WIDTH  = psi_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // avl_pressure, tank_pressure, pump_speed, hw_ready
  input  logic [psi_pkg::IN_DATA_W-1:0] s_tdata,
  // operation
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // safety_state, vent_action, warning_pulse, estop_pulse, overpressure_pulse,
  // check_failed, fault_cause, failure_run, overpressure_count, estop_count,
  // sensor_error_count
  output logic [psi_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psi_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int RUN_W = $clog2(REQUIRED_RUN + 1);
  localparam logic [RUN_W-1:0] RUN_SAT = RUN_W'(REQUIRED_RUN);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // ---------------------------------------------------------------- config
  logic [9:0]         max_pressure;
  logic [9:0]         warning_threshold;
  logic [14:0]        tissue_damage_limit;
  logic signed [15:0] valid_low;
  logic signed [15:0] valid_high;
  logic [7:0]         max_failure_run;
  logic [6:0]         runaway_speed;

  psi_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = psi_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pressure        <= psi_pkg::MAX_PRESSURE_RST;
      warning_threshold   <= psi_pkg::WARN_THRESHOLD_RST;
      tissue_damage_limit <= psi_pkg::TISSUE_LIMIT_RST;
      valid_low           <= psi_pkg::VALID_LOW_RST;
      valid_high          <= psi_pkg::VALID_HIGH_RST;
      max_failure_run     <= psi_pkg::MAX_FAIL_RUN_RST;
      runaway_speed       <= psi_pkg::RUNAWAY_SPEED_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        psi_pkg::REG_MAX_PRESSURE:   max_pressure        <= pwdata[9:0];
        psi_pkg::REG_WARN_THRESHOLD: warning_threshold   <= pwdata[9:0];
        psi_pkg::REG_TISSUE_LIMIT:   tissue_damage_limit <= pwdata[14:0];
        psi_pkg::REG_VALID_LOW:      valid_low           <= $signed(pwdata[15:0]);
        psi_pkg::REG_VALID_HIGH:     valid_high          <= $signed(pwdata[15:0]);
        psi_pkg::REG_MAX_FAIL_RUN:   max_failure_run     <= pwdata[7:0];
        psi_pkg::REG_RUNAWAY_SPEED:  runaway_speed       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      psi_pkg::REG_MAX_PRESSURE:   prdata = 32'(max_pressure);
      psi_pkg::REG_WARN_THRESHOLD: prdata = 32'(warning_threshold);
      psi_pkg::REG_TISSUE_LIMIT:   prdata = 32'(tissue_damage_limit);
      psi_pkg::REG_VALID_LOW:      prdata = 32'(valid_low);
      psi_pkg::REG_VALID_HIGH:     prdata = 32'(valid_high);
      psi_pkg::REG_MAX_FAIL_RUN:   prdata = 32'(max_failure_run);
      psi_pkg::REG_RUNAWAY_SPEED:  prdata = 32'(runaway_speed);
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------- input register
  logic               in_valid;
  psi_pkg::op_t       in_op;
  logic signed [15:0] in_avl;
  logic signed [15:0] in_tank;
  logic [6:0]         in_speed;
  logic               in_ready_hw;
  logic               fire;

  // Evaluate the held beat whenever the result register is free or draining.
  assign fire     = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op       <= psi_pkg::op_t'(s_tuser);
      in_avl      <= $signed(s_tdata[15:0]);
      in_tank     <= $signed(s_tdata[31:16]);
      in_speed    <= s_tdata[38:32];
      in_ready_hw <= s_tdata[39];
    end
  end

  // ------------------------------------------------------------------ state
  psi_pkg::mode_t          mode, mode_next;
  logic [7:0]              fail_run, fail_run_next;
  logic [RUN_W-1:0]        invalid_run, invalid_run_next;
  logic [RUN_W-1:0]        runaway_run, runaway_run_next;
  logic [COUNT_WIDTH-1:0]  overpressure_total, overpressure_total_next;
  logic [COUNT_WIDTH-1:0]  estop_total, estop_total_next;
  logic [COUNT_WIDTH-1:0]  sensor_error_total, sensor_error_total_next;

  // ------------------------------------------------------- condition decode
  logic is_tick, is_sensor, checked;
  logic signed [16:0] avl_x, tank_x, max_x, warn_x, tissue_x, peak_x;
  logic reading_ok, avl_over, tank_over, over_hit, tissue_hit, level_hit;
  logic speed_high, runaway_stop, failed, run_stop;
  logic [7:0] fail_inc;
  psi_pkg::mode_t mode_a, mode_b;

  assign is_tick   = (in_op == psi_pkg::OP_TICK);
  assign is_sensor = (in_op == psi_pkg::OP_SENSOR);
  // Sensor and runaway checks only run on a tick with hardware ready.
  assign checked   = is_tick & in_ready_hw;

  assign avl_x    = 17'(in_avl);
  assign tank_x   = 17'(in_tank);
  assign max_x    = $signed(17'(max_pressure));
  assign warn_x   = $signed(17'(warning_threshold));
  assign tissue_x = $signed(17'(tissue_damage_limit));

  assign reading_ok = (in_avl >= valid_low) && (in_avl <= valid_high) &&
                      (in_tank >= valid_low) && (in_tank <= valid_high);
  assign avl_over   = avl_x > max_x;
  assign tank_over  = tank_x > max_x;
  // Cup reading takes precedence when both are over the limit.
  assign peak_x     = avl_over ? avl_x : tank_x;
  assign over_hit   = checked & reading_ok & (avl_over | tank_over);
  assign tissue_hit = peak_x >= tissue_x;
  assign level_hit  = checked & reading_ok & ~(avl_over | tank_over) &
                      ((avl_x > warn_x) | (tank_x > warn_x));
  assign speed_high = in_speed >= runaway_speed;

  always_comb begin
    invalid_run_next = invalid_run;
    runaway_run_next = runaway_run;
    if (checked) begin
      if (!reading_ok) begin
        invalid_run_next = (invalid_run < RUN_SAT) ? invalid_run + 1'b1 : invalid_run;
      end else begin
        invalid_run_next = '0;
      end
      if (speed_high) begin
        runaway_run_next = (runaway_run < RUN_SAT) ? runaway_run + 1'b1 : runaway_run;
      end else begin
        runaway_run_next = '0;
      end
    end
  end

  assign runaway_stop = checked & (invalid_run_next >= RUN_SAT) &
                        (runaway_run_next >= RUN_SAT) & (mode != psi_pkg::MODE_STOP);
  assign failed       = is_tick & (~in_ready_hw | ~reading_ok | avl_over | tank_over);
  assign fail_inc     = (fail_run == 8'hFF) ? fail_run : fail_run + 8'd1;
  assign run_stop     = failed & (fail_inc >= max_failure_run);

  // Mode after the runaway test, then after the overpressure / level test.
  assign mode_a = runaway_stop ? psi_pkg::MODE_STOP : mode;

  always_comb begin
    if (over_hit) begin
      mode_b = tissue_hit ? psi_pkg::MODE_STOP : psi_pkg::MODE_CRIT;
    end else if (level_hit && mode_a == psi_pkg::MODE_SAFE) begin
      mode_b = psi_pkg::MODE_WARN;
    end else begin
      mode_b = mode_a;
    end
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    mode_next     = mode;
    fail_run_next = fail_run;
    unique case (in_op)
      psi_pkg::OP_TICK: begin
        if (!failed) begin
          fail_run_next = (fail_run != 8'd0) ? fail_run - 8'd1 : fail_run;
          mode_next     = (mode_b == psi_pkg::MODE_WARN) ? psi_pkg::MODE_SAFE : mode_b;
        end else begin
          fail_run_next = fail_inc;
          if (run_stop) begin
            mode_next = psi_pkg::MODE_STOP;
          end else if (mode_b == psi_pkg::MODE_SAFE) begin
            mode_next = psi_pkg::MODE_WARN;
          end else begin
            mode_next = mode_b;
          end
        end
      end
      psi_pkg::OP_CLEAR: begin
        if (mode == psi_pkg::MODE_STOP) begin
          fail_run_next = 8'd0;
          mode_next     = psi_pkg::MODE_SAFE;
        end
      end
      psi_pkg::OP_SENSOR: begin
        if (mode == psi_pkg::MODE_SAFE) begin
          mode_next = psi_pkg::MODE_WARN;
        end
      end
      default: ;
    endcase
  end

  // Up to two stops may be counted in one tick; each step saturates, so a
  // single clamped add gives the same total.
  logic [1:0]             stop_hits;
  logic [COUNT_WIDTH+1:0] estop_sum;

  assign stop_hits = 2'(runaway_stop) + 2'(over_hit & tissue_hit) + 2'(run_stop);
  assign estop_sum = (COUNT_WIDTH+2)'(estop_total) + (COUNT_WIDTH+2)'(stop_hits);

  always_comb begin
    estop_total_next = (estop_sum > (COUNT_WIDTH+2)'(COUNT_MAX)) ?
                       COUNT_MAX : estop_sum[COUNT_WIDTH-1:0];
    overpressure_total_next = overpressure_total;
    if (over_hit && overpressure_total != COUNT_MAX) begin
      overpressure_total_next = overpressure_total + 1'b1;
    end
    sensor_error_total_next = sensor_error_total;
    if (is_sensor && sensor_error_total != COUNT_MAX) begin
      sensor_error_total_next = sensor_error_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= psi_pkg::MODE_SAFE;
      fail_run           <= '0;
      invalid_run        <= '0;
      runaway_run        <= '0;
      overpressure_total <= '0;
      estop_total        <= '0;
      sensor_error_total <= '0;
    end else if (fire) begin
      mode               <= mode_next;
      fail_run           <= fail_run_next;
      invalid_run        <= invalid_run_next;
      runaway_run        <= runaway_run_next;
      overpressure_total <= overpressure_total_next;
      estop_total        <= estop_total_next;
      sensor_error_total <= sensor_error_total_next;
    end
  end

  // ------------------------------------------------------------- beat fields
  logic [1:0]       vent;
  logic             warn_pulse, estop_pulse;
  psi_pkg::cause_t  cause;

  always_comb begin
    vent = 2'b00;
    vent[psi_pkg::VENT_FULL_BIT] = runaway_stop | (over_hit & tissue_hit);
    vent[psi_pkg::VENT_SEAL_BIT] = (over_hit & ~tissue_hit) | run_stop;

    estop_pulse = runaway_stop | (over_hit & tissue_hit) | run_stop;

    // The level warning still pulses even when a passed check returns to safe.
    warn_pulse = (over_hit & ~tissue_hit) |
                 (level_hit & (mode_a == psi_pkg::MODE_SAFE)) |
                 (failed & ~run_stop & (mode_b == psi_pkg::MODE_SAFE)) |
                 (is_sensor & (mode == psi_pkg::MODE_SAFE));
    if (!is_tick && !is_sensor) begin
      warn_pulse = 1'b0;
    end

    priority if (run_stop) begin
      cause = psi_pkg::CAUSE_FAIL_RUN;
    end else if (runaway_stop) begin
      cause = psi_pkg::CAUSE_RUNAWAY;
    end else if (is_tick && !in_ready_hw) begin
      cause = psi_pkg::CAUSE_NOT_READY;
    end else if (is_tick && !reading_ok) begin
      cause = psi_pkg::CAUSE_INVALID;
    end else if (over_hit) begin
      cause = psi_pkg::CAUSE_OVER;
    end else if (is_sensor) begin
      cause = psi_pkg::CAUSE_SENSOR;
    end else begin
      cause = psi_pkg::CAUSE_NONE;
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata[1:0]   <= mode_next;
      m_tdata[3:2]   <= vent;
      m_tdata[4]     <= warn_pulse;
      m_tdata[5]     <= estop_pulse;
      m_tdata[6]     <= over_hit;
      m_tdata[7]     <= failed;
      m_tdata[10:8]  <= cause;
      m_tdata[18:11] <= fail_run_next;
      m_tdata[34:19] <= psi_pkg::REPORT_W'(overpressure_total_next);
      m_tdata[50:35] <= psi_pkg::REPORT_W'(estop_total_next);
      m_tdata[66:51] <= psi_pkg::REPORT_W'(sensor_error_total_next);
      m_tdata[71:67] <= 5'd0;
    end
  end

endmodule
